FILE: hdl/bba_pkg.sv
package bba_pkg;

  // Field widths of the ports
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 12;
  localparam int REQ_W    = 7;
  localparam int CNT_W    = 13;
  localparam int STATUS_W = 2;

  // Bitmap storage: blocks per stored word
  localparam int WORD_W = 8;

  // Defaults for the top-level parameters
  localparam int MAX_BLOCKS_DEF  = 4096;
  localparam int MAX_REQUEST_DEF = 64;

  // Block count after reset
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVE   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

endpackage

FILE: hdl/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/bitmap_block_allocator.sv
// Bitmap block allocator: one used/free bit per block, eight blocks per word
// in a single bitmap RAM.
// Input channel (in_valid / in_stall): one command per transfer. Query,
// mark used and mark free return one result; reserve returns one result per
// contiguous run it claims, lowest free block first, with out_last on the
// final one, and ends with a no-space result if the bitmap runs dry.
// Result channel (out_valid / out_stall): a result register holds each
// result until it is taken; while out_stall is high the sequencer waits
// before loading the next one. Accepting a command does not wait on it.
// Configuration (cfg_valid / cfg_ready): cfg_data sets the block count;
// write it only while no command is in flight. cfg_ready is always high.
// Timing: query and mark pass through the read and load states and load the result
// register on leaving the load state; the block then takes the next command.
// Reserve walks the bitmap RAM from word 0: each word read passes through the
// read and load states, and the scan claims one block per step and spends one
// step per closed run.
// The single RAM read port and the one-bit-per-cycle run walk set the pace.
// Reset: a clearing pass writes every bitmap word (block 0 used, all others
// free); in_stall stays high during it.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bba_pkg::CMD_W-1:0]     in_command,
  input  logic [bba_pkg::IDX_W-1:0]     in_block_index,
  input  logic [bba_pkg::REQ_W-1:0]     in_request_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bba_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_block_free,
  output logic [bba_pkg::IDX_W-1:0]     out_run_first,
  output logic [bba_pkg::IDX_W-1:0]     out_run_last,
  output logic                          out_run_valid,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0]     cfg_data
);

  localparam int DEPTH  = (MAX_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BLK_W  = ADDR_W + 3;
  localparam int CW     = BLK_W + 1;
  localparam int WW     = bba_pkg::WORD_W;
  localparam int RW     = bba_pkg::REQ_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;
  localparam logic [2:0] S_ZERO  = 3'd6;

  // Control state
  logic [2:0]                   state_r, state_nxt;
  logic [ADDR_W-1:0]            clr_r, clr_nxt;
  logic [bba_pkg::CNT_W-1:0]    block_count_r, block_count_nxt;
  logic                         in_run_r, in_run_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Working registers
  logic [bba_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic                         range_r, range_nxt;
  logic [ADDR_W-1:0]            addr_r, addr_nxt;
  logic [2:0]                   pos_r, pos_nxt;
  logic [WW-1:0]                word_r, word_nxt;
  logic [RW-1:0]                want_r, want_nxt;
  logic [RW-1:0]                got_r, got_nxt;
  logic [BLK_W-1:0]             first_r, first_nxt;
  logic [BLK_W-1:0]             last_blk_r, last_blk_nxt;

  // Result register
  logic [bba_pkg::STATUS_W-1:0] status_r;
  logic                         free_r;
  logic [bba_pkg::IDX_W-1:0]    run_first_r, run_last_r;
  logic                         run_valid_r, last_r;

  // RAM port
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [WW-1:0]                wr_data;
  logic [WW-1:0]                rd_data;

  // Datapath terms
  logic [CW-1:0]                vc;
  logic                         in_range;
  logic [BLK_W-1:0]             blk_ext;
  logic [RW-1:0]                want_sat;
  logic [BLK_W-1:0]             base;
  logic [WW-1:0]                rng_mask;
  logic [WW-1:0]                free_w, free_rd, cand;
  logic [2:0]                   low_p;
  logic                         claim;
  logic [2:0]                   claim_pos;
  logic [BLK_W-1:0]             claim_blk;
  logic [WW-1:0]                word_claim;
  logic [RW-1:0]                got_inc;
  logic                         end_next;
  logic                         bit_used, mark_ok;
  logic                         out_ok;

  // Emitted result
  logic                         emit;
  logic [bba_pkg::STATUS_W-1:0] e_status;
  logic                         e_free;
  logic [BLK_W-1:0]             e_first, e_last_blk;
  logic                         e_rv, e_last;

  bba_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // Clamp the block count to the bitmap size
  assign vc = (32'(block_count_r) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                     : CW'(block_count_r);
  assign in_range = 32'(in_block_index) < 32'(vc);
  assign blk_ext  = BLK_W'(in_block_index);
  assign want_sat = (in_request_count > RW'(MAX_REQUEST)) ? RW'(MAX_REQUEST)
                                                          : in_request_count;

  // Per-word free masks, limited to blocks below the count
  assign base = {addr_r, 3'b000};
  always_comb begin
    for (int j = 0; j < WW; j++) begin
      rng_mask[j] = ({1'b0, base} + CW'(j)) < vc;
    end
  end
  assign free_w  = ~word_r & rng_mask;
  assign free_rd = ~rd_data & rng_mask;

  // Free bits at or above the current position
  always_comb begin
    for (int j = 0; j < WW; j++) begin
      cand[j] = free_w[j] && (3'(j) >= pos_r);
    end
  end

  // Lowest candidate bit
  always_comb begin
    low_p = 3'd0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (cand[j]) begin
        low_p = 3'(j);
      end
    end
  end

  // Claim: extend an open run at pos, or open one at the lowest free bit
  assign claim      = in_run_r ? free_w[pos_r] : (cand != '0);
  assign claim_pos  = in_run_r ? pos_r : low_p;
  assign claim_blk  = {addr_r, claim_pos};
  assign word_claim = word_r | (WW'(1) << claim_pos);
  assign got_inc    = got_r + RW'(1);
  assign end_next   = (addr_r == ADDR_W'(DEPTH - 1)) ||
                      (({1'b0, base} + CW'(WW)) >= vc);

  // Single-block command outcome
  assign bit_used = rd_data[pos_r];
  assign mark_ok  = range_r && ((cmd_r == bba_pkg::CMD_MARK_USED) ? !bit_used : bit_used);

  assign out_ok = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    block_count_nxt = block_count_r;
    in_run_nxt      = in_run_r;
    cmd_nxt         = cmd_r;
    range_nxt       = range_r;
    addr_nxt        = addr_r;
    pos_nxt         = pos_r;
    word_nxt        = word_r;
    want_nxt        = want_r;
    got_nxt         = got_r;
    first_nxt       = first_r;
    last_blk_nxt    = last_blk_r;
    wr_en           = 1'b0;
    wr_addr         = addr_r;
    wr_data         = word_r;
    emit            = 1'b0;
    e_status        = bba_pkg::ST_DONE;
    e_free          = 1'b0;
    e_first         = '0;
    e_last_blk      = '0;
    e_rv            = 1'b0;
    e_last          = 1'b0;

    // Take configuration writes at any time
    if (cfg_valid) begin
      block_count_nxt = cfg_data;
    end

    unique case (state_r)
      S_CLEAR: begin
        // Sweep the bitmap: block 0 used, all others free
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = (clr_r == '0) ? WW'(1) : '0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          range_nxt  = in_range;
          want_nxt   = want_sat;
          got_nxt    = '0;
          in_run_nxt = 1'b0;
          if (in_command == bba_pkg::CMD_RESERVE) begin
            addr_nxt  = '0;
            pos_nxt   = '0;
            state_nxt = (want_sat == '0) ? S_ZERO : S_RD;
          end else begin
            addr_nxt  = blk_ext[BLK_W-1:3];
            pos_nxt   = blk_ext[2:0];
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (cmd_r == bba_pkg::CMD_RESERVE) begin
          // Skip fully used words while no run is open
          word_nxt = rd_data;
          if (!in_run_r && (free_rd == '0)) begin
            if (end_next) begin
              state_nxt = S_TAIL;
            end else begin
              addr_nxt  = addr_r + ADDR_W'(1);
              state_nxt = S_RD;
            end
          end else begin
            pos_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end else begin
          emit   = 1'b1;
          e_last = 1'b1;
          case (cmd_r)
            bba_pkg::CMD_QUERY: begin
              e_status = range_r ? bba_pkg::ST_DONE : bba_pkg::ST_REJECTED;
              e_free   = range_r && !bit_used;
            end
            default: begin
              e_status = mark_ok ? bba_pkg::ST_DONE : bba_pkg::ST_REJECTED;
            end
          endcase
          if (out_ok) begin
            wr_en     = (cmd_r != bba_pkg::CMD_QUERY) && mark_ok;
            wr_data   = rd_data ^ (WW'(1) << pos_r);
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (claim && (got_inc == want_r)) begin
          // Final block: report the run and write the word back
          emit       = 1'b1;
          e_first    = in_run_r ? first_r : claim_blk;
          e_last_blk = claim_blk;
          e_rv       = 1'b1;
          e_last     = 1'b1;
          if (out_ok) begin
            wr_en     = 1'b1;
            wr_data   = word_claim;
            state_nxt = S_IDLE;
          end
        end else if (claim) begin
          // Claim one block and advance
          word_nxt     = word_claim;
          got_nxt      = got_inc;
          last_blk_nxt = claim_blk;
          in_run_nxt   = 1'b1;
          if (!in_run_r) begin
            first_nxt = claim_blk;
          end
          if (claim_pos == 3'd7) begin
            wr_en   = 1'b1;
            wr_data = word_claim;
            pos_nxt = '0;
            if (end_next) begin
              state_nxt = S_TAIL;
            end else begin
              addr_nxt  = addr_r + ADDR_W'(1);
              state_nxt = S_RD;
            end
          end else begin
            pos_nxt = claim_pos + 3'd1;
          end
        end else if (in_run_r) begin
          // Run hit a used block: close it
          emit       = 1'b1;
          e_first    = first_r;
          e_last_blk = last_blk_r;
          e_rv       = 1'b1;
          if (out_ok) begin
            in_run_nxt = 1'b0;
          end
        end else begin
          // Nothing free left in this word: move on
          wr_en   = 1'b1;
          wr_data = word_r;
          pos_nxt = '0;
          if (end_next) begin
            state_nxt = S_TAIL;
          end else begin
            addr_nxt  = addr_r + ADDR_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_TAIL: begin
        // Bitmap exhausted: close any open run, then report no space
        emit = 1'b1;
        if (in_run_r) begin
          e_first    = first_r;
          e_last_blk = last_blk_r;
          e_rv       = 1'b1;
          if (out_ok) begin
            in_run_nxt = 1'b0;
          end
        end else begin
          e_status = bba_pkg::ST_NO_SPACE;
          e_last   = 1'b1;
          if (out_ok) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ZERO: begin
        emit   = 1'b1;
        e_last = 1'b1;
        if (out_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit && out_ok) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      block_count_r <= bba_pkg::BLOCK_COUNT_RESET;
      in_run_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      block_count_r <= block_count_nxt;
      in_run_r      <= in_run_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    range_r    <= range_nxt;
    addr_r     <= addr_nxt;
    pos_r      <= pos_nxt;
    word_r     <= word_nxt;
    want_r     <= want_nxt;
    got_r      <= got_nxt;
    first_r    <= first_nxt;
    last_blk_r <= last_blk_nxt;
    if (emit && out_ok) begin
      status_r    <= e_status;
      free_r      <= e_free;
      run_first_r <= bba_pkg::IDX_W'(e_first);
      run_last_r  <= bba_pkg::IDX_W'(e_last_blk);
      run_valid_r <= e_rv;
      last_r      <= e_last;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_block_free = free_r;
  assign out_run_first  = run_first_r;
  assign out_run_last   = run_last_r;
  assign out_run_valid  = run_valid_r;
  assign out_last       = last_r;

endmodule

FILE: hdl/bba_checker.sv
module bba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [bba_pkg::CMD_W-1:0]     in_command,
  input logic [bba_pkg::IDX_W-1:0]     in_block_index,
  input logic [bba_pkg::REQ_W-1:0]     in_request_count,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bba_pkg::STATUS_W-1:0]  out_status,
  input logic                          out_block_free,
  input logic [bba_pkg::IDX_W-1:0]     out_run_first,
  input logic [bba_pkg::IDX_W-1:0]     out_run_last,
  input logic                          out_run_valid,
  input logic                          out_last,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [bba_pkg::CNT_W-1:0]     cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_run_first) && $stable(out_run_last) && $stable(out_last))
    else $error("stalled result changed");

  // A reported run is done and ordered
  a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_valid |->
      out_status == bba_pkg::ST_DONE && out_run_first <= out_run_last &&
      !out_block_free)
    else $error("malformed run result");

  // Out of space ends the command and carries no run
  a_nospace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bba_pkg::ST_NO_SPACE |-> out_last && !out_run_valid)
    else $error("no-space result not final");

  // A free answer is a single final result
  a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_free |->
      out_last && out_status == bba_pkg::ST_DONE && !out_run_valid)
    else $error("bad query answer");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

FILE: tb/sv/bba_reply_checker.sv
module bba_reply_checker #(
  parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bba_pkg::CMD_W-1:0]     in_command,
  input  logic [bba_pkg::IDX_W-1:0]     in_block_index,
  input  logic [bba_pkg::REQ_W-1:0]     in_request_count,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bba_pkg::STATUS_W-1:0]  out_status,
  input  logic                          out_block_free,
  input  logic [bba_pkg::IDX_W-1:0]     out_run_first,
  input  logic [bba_pkg::IDX_W-1:0]     out_run_last,
  input  logic                          out_run_valid,
  input  logic                          out_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0]     cfg_data,
  output int                            pending,
  output int                            fail_count
);

  typedef struct packed {
    logic [bba_pkg::STATUS_W-1:0] status;
    logic                         block_free;
    logic [bba_pkg::IDX_W-1:0]    run_first;
    logic [bba_pkg::IDX_W-1:0]    run_last;
    logic                         run_valid;
    logic                         last;
  } reply_t;

  logic                      used_map [0:MAX_BLOCKS-1];
  logic [bba_pkg::CNT_W-1:0] block_count_q;
  reply_t                    due_replies [$];
  reply_t                    owed;
  int                        mismatch_count = 0;

  assign fail_count = mismatch_count;

  // Blocks in use: counts above the store size act as the store size
  function automatic int live_blocks();
    return (block_count_q > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count_q);
  endfunction

  // Append one reply to the back of the owed list
  task automatic queue_reply(input reply_t rep);
    due_replies = {due_replies, rep};
  endtask

  task automatic clear_map();
    for (int b = 0; b < MAX_BLOCKS; b++) used_map[b] = 1'b0;
    used_map[0]   = 1'b1;
    block_count_q = bba_pkg::BLOCK_COUNT_RESET;
    due_replies.delete();
  endtask

  // Update the bitmap for one command and queue the replies it owes
  task automatic apply_command(input logic [bba_pkg::CMD_W-1:0] cmd,
                               input logic [bba_pkg::IDX_W-1:0] idx,
                               input logic [bba_pkg::REQ_W-1:0] req);
    reply_t r;
    int     nblk;
    int     want;
    int     got;
    int     first;
    int     second;
    int     b;
    bit     found;
    bit     dry;
    nblk = live_blocks();
    r = '0;
    r.last = 1'b1;
    case (cmd)
      bba_pkg::CMD_QUERY: begin
        if (idx >= nblk) begin
          r.status = bba_pkg::ST_REJECTED;
        end else begin
          r.status     = bba_pkg::ST_DONE;
          r.block_free = !used_map[idx];
        end
        queue_reply(r);
      end
      bba_pkg::CMD_MARK_USED, bba_pkg::CMD_MARK_FREE: begin
        // mark used needs a free block, mark free a used one
        if (idx < nblk && (!used_map[idx]) == (cmd == bba_pkg::CMD_MARK_USED)) begin
          used_map[idx] = !used_map[idx];
          r.status = bba_pkg::ST_DONE;
        end else begin
          r.status = bba_pkg::ST_REJECTED;
        end
        queue_reply(r);
      end
      default: begin
        want = (req > MAX_REQUEST) ? MAX_REQUEST : int'(req);
        got  = 0;
        dry  = 1'b0;
        if (want == 0) begin
          r.status = bba_pkg::ST_DONE;
          queue_reply(r);
        end
        while (got < want && !dry) begin
          // find the lowest free block in range
          first = 0;
          found = 1'b0;
          while (!found && first < nblk) begin
            if (!used_map[first]) found = 1'b1;
            else first++;
          end
          r = '0;
          if (!found) begin
            r.status = bba_pkg::ST_NO_SPACE;
            r.last   = 1'b1;
            dry      = 1'b1;
          end else begin
            // grow the run while the next block is free and more are wanted
            second = first;
            got++;
            while (got < want && second + 1 < nblk && !used_map[second + 1]) begin
              second++;
              got++;
            end
            for (b = first; b <= second; b++) used_map[b] = 1'b1;
            r.status    = bba_pkg::ST_DONE;
            r.run_first = bba_pkg::IDX_W'(first);
            r.run_last  = bba_pkg::IDX_W'(second);
            r.run_valid = 1'b1;
            r.last      = (got >= want);
          end
          queue_reply(r);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] exp,
                             input logic [15:0] got);
    if (got !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      mismatch_count++;
    end
  endtask

  // Sample every channel at the rising edge: config, then commands, then results
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_map();
    end else begin
      if (cfg_valid && cfg_ready) block_count_q = cfg_data;
      if (in_valid && !in_stall) apply_command(in_command, in_block_index, in_request_count);
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          $error("result transfer with no reply owed");
          mismatch_count++;
        end else begin
          owed = due_replies.pop_front();
          check_field("status", 16'(owed.status), 16'(out_status));
          check_field("block_free", 16'(owed.block_free), 16'(out_block_free));
          check_field("run_first", 16'(owed.run_first), 16'(out_run_first));
          check_field("run_last", 16'(owed.run_last), 16'(out_run_last));
          check_field("run_valid", 16'(owed.run_valid), 16'(out_run_valid));
          check_field("last", 16'(owed.last), 16'(out_last));
        end
      end
    end
    pending <= due_replies.size();
  end

endmodule

FILE: tb/sv/tb_bitmap_block_allocator.sv
module tb_bitmap_block_allocator;

  logic                         clk              = 1'b0;
  logic                         rst_n            = 1'b0;
  logic                         in_valid         = 1'b0;
  logic                         in_stall;
  logic [bba_pkg::CMD_W-1:0]    in_command       = bba_pkg::CMD_QUERY;
  logic [bba_pkg::IDX_W-1:0]    in_block_index   = '0;
  logic [bba_pkg::REQ_W-1:0]    in_request_count = '0;
  logic                         out_valid;
  logic                         out_stall        = 1'b0;
  logic [bba_pkg::STATUS_W-1:0] out_status;
  logic                         out_block_free;
  logic [bba_pkg::IDX_W-1:0]    out_run_first;
  logic [bba_pkg::IDX_W-1:0]    out_run_last;
  logic                         out_run_valid;
  logic                         out_last;
  logic                         cfg_valid        = 1'b0;
  logic                         cfg_ready;
  logic [bba_pkg::CNT_W-1:0]    cfg_data         = bba_pkg::BLOCK_COUNT_RESET;

  int pending;
  int fail_count;
  int cur_blocks = int'(bba_pkg::BLOCK_COUNT_RESET);
  bit calm       = 1'b0;

  always #6 clk = ~clk;

  bitmap_block_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_block_index   (in_block_index),
    .in_request_count (in_request_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_block_free   (out_block_free),
    .out_run_first    (out_run_first),
    .out_run_last     (out_run_last),
    .out_run_valid    (out_run_valid),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  bba_reply_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_block_index   (in_block_index),
    .in_request_count (in_request_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_block_free   (out_block_free),
    .out_run_first    (out_run_first),
    .out_run_last     (out_run_last),
    .out_run_valid    (out_run_valid),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .pending          (pending),
    .fail_count       (fail_count)
  );

  // Present one command and hold it until the transfer
  task automatic send_cmd(input logic [bba_pkg::CMD_W-1:0] c, input int idx,
                          input int req);
    in_valid         <= 1'b1;
    in_command       <= c;
    in_block_index   <= bba_pkg::IDX_W'(idx);
    in_request_count <= bba_pkg::REQ_W'(req);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic rest_in(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until every owed reply has come back, then let the block settle
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_block_count(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= bba_pkg::CNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    cur_blocks  = value;
  endtask

  // Random command, mostly aimed at the low end where reserves land
  task automatic send_random();
    logic [bba_pkg::CMD_W-1:0] c;
    int                        idx;
    int                        req;
    int                        pick;
    int                        reach;
    reach = (cur_blocks > bba_pkg::MAX_BLOCKS_DEF) ? bba_pkg::MAX_BLOCKS_DEF : cur_blocks;
    pick  = $urandom_range(0, 99);
    if (pick < 22)      c = bba_pkg::CMD_QUERY;
    else if (pick < 42) c = bba_pkg::CMD_MARK_USED;
    else if (pick < 67) c = bba_pkg::CMD_MARK_FREE;
    else                c = bba_pkg::CMD_RESERVE;
    case ($urandom_range(0, 9))
      0:       idx = $urandom;
      1:       idx = reach - 1 + $urandom_range(0, 1);
      default: idx = $urandom_range(0, ((reach < 160) ? reach : 160) - 1);
    endcase
    case ($urandom_range(0, 9))
      0:       req = $urandom;
      1:       req = $urandom_range(9, bba_pkg::MAX_REQUEST_DEF);
      default: req = $urandom_range(0, 8);
    endcase
    if (!calm && $urandom_range(0, 3) == 0) rest_in($urandom_range(1, 17));
    send_cmd(c, idx, req);
  endtask

  task automatic random_phase(input int count, input int items);
    set_block_count(count);
    repeat (items) send_random();
    drain_replies();
  endtask

  // Stall the result channel in random bursts, with quiet stretches
  initial begin
    forever begin
      @(posedge clk);
      if (!calm) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clk);
            out_stall <= 1'b0;
          end
          4: repeat ($urandom_range(20, 80)) @(posedge clk);
          default: ;
        endcase
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb_bitmap_block_allocator NOT OK");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: queries, block zero, repeated marks, zero and saturated reserves
    send_cmd(bba_pkg::CMD_QUERY, 0, 0);
    send_cmd(bba_pkg::CMD_QUERY, 1, 0);
    send_cmd(bba_pkg::CMD_QUERY, 4095, 127);
    send_cmd(bba_pkg::CMD_MARK_FREE, 0, 0);
    send_cmd(bba_pkg::CMD_MARK_FREE, 0, 0);
    send_cmd(bba_pkg::CMD_QUERY, 0, 0);
    send_cmd(bba_pkg::CMD_RESERVE, 0, 1);
    send_cmd(bba_pkg::CMD_MARK_USED, 4095, 0);
    send_cmd(bba_pkg::CMD_MARK_USED, 4095, 0);
    send_cmd(bba_pkg::CMD_RESERVE, 4095, 0);
    send_cmd(bba_pkg::CMD_RESERVE, 0, 127);
    send_cmd(bba_pkg::CMD_MARK_FREE, 10, 0);
    send_cmd(bba_pkg::CMD_MARK_FREE, 20, 0);
    send_cmd(bba_pkg::CMD_RESERVE, 0, 5);
    send_cmd(bba_pkg::CMD_RESERVE, 0, 64);
    drain_replies();

    // Directed: small store runs dry, indexes past the count are rejected
    set_block_count(8);
    send_cmd(bba_pkg::CMD_MARK_FREE, 3, 0);
    send_cmd(bba_pkg::CMD_MARK_FREE, 5, 0);
    send_cmd(bba_pkg::CMD_RESERVE, 0, 4);
    send_cmd(bba_pkg::CMD_QUERY, 8, 0);
    send_cmd(bba_pkg::CMD_MARK_FREE, 100, 0);
    send_cmd(bba_pkg::CMD_MARK_USED, 4095, 0);
    drain_replies();

    // Random phases over several block counts, extremes included
    random_phase(1, 20);
    random_phase(13, 50);
    random_phase(8191, 60);
    random_phase(40, 50);
    random_phase(4096, 60);
    calm = 1'b1;
    random_phase(100, 60);

    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_bitmap_block_allocator OK");
    end else begin
      $display("tb_bitmap_block_allocator NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bitmap_block_allocator.sv
hdl/bba_checker.sv
tb/sv/bba_reply_checker.sv
tb/sv/tb_bitmap_block_allocator.sv
